/* hw/rtl/sldf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_pkg - shared types and constants of the frame deframer
// Header phases, result record layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package sldf_pkg;

  // register indexes on the configuration port
  localparam logic CFG_SYNC  = 1'b0;
  localparam logic CFG_START = 1'b1;

  // reset values of the header registers
  localparam logic [7:0] SYNC_RESET  = 8'h55;
  localparam logic [7:0] START_RESET = 8'h7A;

  // position of the length byte, and the command position just after it
  localparam logic [8:0] LEN_POS = 9'd2;
  localparam logic [8:0] CMD_POS = 9'd3;

  // length bytes below this value are malformed
  localparam logic [7:0] MIN_LEN = 8'd2;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // one result record
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_pos;
    logic [7:0] cmd_code;
    logic       frame_end;
    logic       malformed;
  } rec_t;

  // front to queue push request
  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* hw/rtl/sldf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_front - header hunt and byte classification
// Holds the header registers and frame state, turns each accepted byte into
// zero or one result record and pushes it to the queue.
// ----------------------------------------------------------------------------
module sldf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic [7:0]          in_rx_byte,
  input  sldf_pkg::qstat_t    qstat,
  output logic                in_stall,
  output sldf_pkg::push_t     push
);
  import sldf_pkg::*;

  logic [7:0] sync_r;
  logic [7:0] start_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       accept;
  logic [8:0] last_pos;
  logic       is_end;
  logic [7:0] cmd_cur;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= SYNC_RESET;
      start_r <= START_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SYNC:  sync_r  <= cfg_data;
        CFG_START: start_r <= cfg_data;
        default:   sync_r  <= sync_r;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      pos_r   <= '0;
      cmd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // last frame position is L+1
  assign last_pos = {1'b0, len_r} + 9'd1;
  assign is_end   = (pos_r >= last_pos);
  assign cmd_cur  = (pos_r == CMD_POS) ? in_rx_byte : cmd_r;

  // next state and push record
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    push.valid          = 1'b0;
    push.rec.frame_byte = in_rx_byte;
    push.rec.byte_pos   = LEN_POS;
    push.rec.cmd_code   = '0;
    push.rec.frame_end  = 1'b0;
    push.rec.malformed  = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == sync_r) phase_nxt = PH_SYNC;
        end
        PH_SYNC: begin
          // start byte checked first so equal header bytes still work
          priority if (in_rx_byte == start_r) phase_nxt = PH_LEN;
          else if (in_rx_byte != sync_r)      phase_nxt = PH_HUNT;
        end
        PH_LEN: begin
          push.valid = 1'b1;
          cmd_nxt    = '0;
          if (in_rx_byte < MIN_LEN) begin
            push.rec.malformed = 1'b1;
            phase_nxt = PH_HUNT;
            len_nxt   = '0;
            pos_nxt   = '0;
          end else begin
            phase_nxt = PH_BODY;
            len_nxt   = in_rx_byte;
            pos_nxt   = CMD_POS;
          end
        end
        PH_BODY: begin
          push.valid         = 1'b1;
          push.rec.byte_pos  = pos_r;
          push.rec.cmd_code  = cmd_cur;
          push.rec.frame_end = is_end;
          cmd_nxt            = cmd_cur;
          if (is_end) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end else begin
            pos_nxt   = pos_r + 9'd1;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

endmodule

/* hw/rtl/sldf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_queue - short record queue between front and back
// Two-entry ring of result records with fill count.
// ----------------------------------------------------------------------------
module sldf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sldf_pkg::push_t  push,
  input  logic             pop,
  output sldf_pkg::rec_t   head,
  output sldf_pkg::qstat_t qstat
);
  import sldf_pkg::*;

  rec_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = ent_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push.rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* hw/rtl/sldf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_back - result output register
// Pops records from the queue and holds each on the result ports until taken.
// ----------------------------------------------------------------------------
module sldf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sldf_pkg::rec_t   head,
  input  sldf_pkg::qstat_t qstat,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_frame_byte,
  output logic [8:0]       out_byte_pos,
  output logic [7:0]       out_cmd_code,
  output logic             out_frame_end,
  output logic             out_malformed
);
  import sldf_pkg::*;

  logic valid_r;
  rec_t rec_r;

  // load when the register is empty or its request is being taken
  assign pop = !qstat.empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= head;
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = rec_r.frame_byte;
  assign out_byte_pos   = rec_r.byte_pos;
  assign out_cmd_code   = rec_r.cmd_code;
  assign out_frame_end  = rec_r.frame_end;
  assign out_malformed  = rec_r.malformed;

endmodule

/* hw/rtl/sync_length_frame_deframer.sv */
`timescale 1ns / 1ps
// each result goes through the queue and then the output register to the out ports
// throughput: one byte per cycle while the queue is not full, set by the frame state update
// the two-entry queue lets the front keep accepting while a result waits
// header bytes produce no result; every frame byte from the length on gives one
// reset: synchronous active-low rst_n clears queue, output and frame state,
// and loads the header registers with 0x55 and 0x7a
// ----------------------------------------------------------------------------
// sync_length_frame_deframer - length-prefixed frame deframer
// Hunts for the sync/start header, then emits each frame byte with its
// position, command code and end-of-frame mark.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_pos,
  output logic [7:0] out_cmd_code,
  output logic       out_frame_end,
  output logic       out_malformed
);
  import sldf_pkg::*;

  push_t  push;
  qstat_t qstat;
  rec_t   head;
  logic   pop;

  // front: header hunt and classification
  sldf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .qstat      (qstat),
    .in_stall   (in_stall),
    .push       (push)
  );

  // queue between the two sides
  sldf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // back: output register
  sldf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_byte_pos   (out_byte_pos),
    .out_cmd_code   (out_cmd_code),
    .out_frame_end  (out_frame_end),
    .out_malformed  (out_malformed)
  );

endmodule

/* hw/rtl/sldf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_checker - port-level assertions of the frame deframer
// Watches the result ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sldf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic [8:0] out_byte_pos,
  input logic [7:0] out_cmd_code,
  input logic       out_frame_end,
  input logic       out_malformed
);

  // a stalled request stays up
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled request keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_frame_byte) && $stable(out_byte_pos)
      && $stable(out_cmd_code) && $stable(out_frame_end) && $stable(out_malformed))
    else $error("out payload changed while stalled");

  // malformed length is reported on the length byte alone
  a_malformed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |-> out_byte_pos == 9'd2 && !out_frame_end
      && out_cmd_code == 8'd0 && out_frame_byte < 8'd2)
    else $error("malformed result with bad fields");

  // length byte carries no command and ends no frame
  a_len_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_pos == 9'd2 |-> out_cmd_code == 8'd0 && !out_frame_end)
    else $error("length byte result with command or end mark");

  // positions stay in the frame range
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_pos >= 9'd2 && out_byte_pos <= 9'd256)
    else $error("byte position out of range");

endmodule

bind sync_length_frame_deframer sldf_checker u_sldf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_byte_pos   (out_byte_pos),
  .out_cmd_code   (out_cmd_code),
  .out_frame_end  (out_frame_end),
  .out_malformed  (out_malformed)
);
